[hdl/pse_pkg.sv]
// Shared types and constants for the PDF string escape codec.
// Used by the interfaces and all codec modules; depends on nothing.
package pse_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int CAP_WIDTH      = 24;
   localparam int CSR_IDX_WIDTH  = 4;
   localparam int ENTRY_BYTES    = 4;
   localparam int ENTRY_CNT_W    = 3;

   typedef enum logic [1:0] {
      MODE_LITERAL = 2'd0,
      MODE_NAME    = 2'd1,
      MODE_HEX_ENC = 2'd2,
      MODE_HEX_DEC = 2'd3
   } pse_mode_type;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODE     = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CAPACITY = 4'd1;

   typedef struct packed {
      logic [ENTRY_BYTES-1:0][BYTE_WIDTH-1:0] bytes;
      logic [ENTRY_CNT_W-1:0]                 count;
      logic                                   last;
      logic                                   ovf;
   } pse_entry_type;

endpackage

[hdl/pse_req_if.sv]
// Input byte channel of the PDF string escape codec.
// Depends on pse_pkg for field widths.
interface pse_req_if;
   logic                            valid;
   logic                            ready;
   logic [pse_pkg::BYTE_WIDTH-1:0]  in_byte;
   logic                            last_byte;

   modport source (output valid, in_byte, last_byte, input ready);
   modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

[hdl/pse_rsp_if.sv]
// Result byte channel of the PDF string escape codec.
// Depends on pse_pkg for field widths.
interface pse_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pse_pkg::BYTE_WIDTH-1:0]  out_byte;
   logic                            byte_valid;
   logic                            end_of_string;
   logic                            overflow;

   modport source (output valid, out_byte, byte_valid, end_of_string, overflow, input ready);
   modport sink   (input valid, out_byte, byte_valid, end_of_string, overflow, output ready);
endinterface

[hdl/pse_csr_if.sv]
// Configuration write channel of the PDF string escape codec.
// Depends on pse_pkg for index and data widths.
interface pse_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pse_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [pse_pkg::CAP_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/pse_front.sv]
// Front end: configuration registers, capacity check and per-byte escape.
// Pushes at most one entry of up to four output bytes per transfer into the queue.
// Depends on pse_pkg, pse_req_if and pse_csr_if.
module pse_front #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   pse_req_if.sink                req_if,
   pse_csr_if.sink                csr_if,
   output logic                   push_valid,
   input  logic                   push_ready,
   output pse_pkg::pse_entry_type push_entry
);

   localparam int EW = ((COUNT_WIDTH > pse_pkg::CAP_WIDTH) ?
                        COUNT_WIDTH : pse_pkg::CAP_WIDTH) + 1;
   localparam logic [EW-1:0] COUNT_MAX =
      {{(EW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_ZERO   = 8'd48;

   pse_pkg::pse_mode_type             mode_ff;
   logic [pse_pkg::CAP_WIDTH-1:0]     capacity_ff;
   logic [COUNT_WIDTH-1:0]            bytes_written_ff, bytes_written_in;
   logic [3:0]                        pending_nibble_ff, pending_nibble_in;
   logic                              nibble_waiting_ff, nibble_waiting_in;
   logic                              overflowed_ff, overflowed_in;

   logic [7:0]     c;
   logic           last;
   logic           accept;
   logic [2:0]     margin;
   logic [EW-1:0]  cap_ext, cap_eff, sum;
   logic           ovf_now;
   logic [3:0][7:0] b;
   logic [2:0]     n;
   logic           hex_ok;
   logic [3:0]     hex_val;
   logic           wait_next;
   logic [3:0]     pend_next;

   function automatic logic [7:0] hex_ascii(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'd48 + {4'd0, v};
      end else begin
         r = 8'd55 + {4'd0, v};
      end
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] x);
      return x == 8'd35 || x == 8'd37 || x == 8'd40 || x == 8'd41 || x == 8'd47 ||
             x == 8'd60 || x == 8'd62 || x == 8'd91 || x == 8'd93 || x == 8'd123 ||
             x == 8'd125;
   endfunction

   assign c      = req_if.in_byte;
   assign last   = req_if.last_byte;
   assign req_if.ready = push_ready;
   assign accept = req_if.valid && push_ready;
   assign csr_if.ready = 1'b1;

   always_comb begin
      case (mode_ff)
         pse_pkg::MODE_LITERAL: margin = 3'd4;
         pse_pkg::MODE_NAME:    margin = 3'd3;
         pse_pkg::MODE_HEX_ENC: margin = 3'd2;
         default:               margin = 3'd1;
      endcase
      cap_ext = EW'(capacity_ff);
      cap_eff = (cap_ext > COUNT_MAX) ? COUNT_MAX : cap_ext;
      sum     = EW'(bytes_written_ff) + EW'(margin);
      ovf_now = overflowed_ff || (sum >= cap_eff);
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         hex_val = c[3:0];
      end else if ((c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      b         = '0;
      n         = 3'd0;
      wait_next = nibble_waiting_ff;
      pend_next = pending_nibble_ff;
      if (!ovf_now) begin
         case (mode_ff)
            pse_pkg::MODE_LITERAL: begin
               if (c < 8'd33 || c > 8'd126) begin
                  b[0] = CH_BSLASH;
                  b[1] = CH_ZERO + {6'd0, c[7:6]};
                  b[2] = CH_ZERO + {5'd0, c[5:3]};
                  b[3] = CH_ZERO + {5'd0, c[2:0]};
                  n    = 3'd4;
               end else if (c == 8'd40 || c == 8'd41 || c == CH_BSLASH) begin
                  b[0] = CH_BSLASH;
                  b[1] = c;
                  n    = 3'd2;
               end else begin
                  b[0] = c;
                  n    = 3'd1;
               end
            end
            pse_pkg::MODE_NAME: begin
               if (c == 8'd0) begin
                  n = 3'd0;
               end else if (c <= 8'd32 || c >= 8'd127 || is_delim(c)) begin
                  b[0] = CH_HASH;
                  b[1] = hex_ascii(c[7:4]);
                  b[2] = hex_ascii(c[3:0]);
                  n    = 3'd3;
               end else begin
                  b[0] = c;
                  n    = 3'd1;
               end
            end
            pse_pkg::MODE_HEX_ENC: begin
               b[0] = hex_ascii(c[7:4]);
               b[1] = hex_ascii(c[3:0]);
               n    = 3'd2;
            end
            default: begin
               if (hex_ok) begin
                  if (!nibble_waiting_ff) begin
                     pend_next = hex_val;
                     wait_next = 1'b1;
                  end else begin
                     b[0]      = {pending_nibble_ff, hex_val};
                     n         = 3'd1;
                     wait_next = 1'b0;
                  end
               end
               if (last && wait_next) begin
                  b[0]      = {pend_next, 4'd0};
                  n         = 3'd1;
                  wait_next = 1'b0;
               end
            end
         endcase
      end
   end

   always_comb begin
      push_valid       = accept && (n != 3'd0 || last);
      push_entry.bytes = b;
      push_entry.count = n;
      push_entry.last  = last;
      push_entry.ovf   = ovf_now;

      bytes_written_in  = bytes_written_ff;
      nibble_waiting_in = nibble_waiting_ff;
      overflowed_in     = overflowed_ff;
      pending_nibble_in = pending_nibble_ff;
      if (accept) begin
         pending_nibble_in = pend_next;
         if (last) begin
            bytes_written_in  = '0;
            nibble_waiting_in = 1'b0;
            overflowed_in     = 1'b0;
         end else begin
            bytes_written_in  = bytes_written_ff + COUNT_WIDTH'(n);
            nibble_waiting_in = wait_next;
            overflowed_in     = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= pse_pkg::MODE_LITERAL;
         capacity_ff       <= '1;
         bytes_written_ff  <= '0;
         pending_nibble_ff <= '0;
         nibble_waiting_ff <= 1'b0;
         overflowed_ff     <= 1'b0;
      end else begin
         bytes_written_ff  <= bytes_written_in;
         pending_nibble_ff <= pending_nibble_in;
         nibble_waiting_ff <= nibble_waiting_in;
         overflowed_ff     <= overflowed_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               pse_pkg::CSR_MODE:     mode_ff <= pse_pkg::pse_mode_type'(csr_if.data[1:0]);
               pse_pkg::CSR_CAPACITY: capacity_ff <= csr_if.data;
               default: ;
            endcase
         end
      end
   end

endmodule

[hdl/pse_queue.sv]
// Short entry queue between the codec front and back ends.
// Depends on pse_pkg for the entry type.
module pse_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  pse_pkg::pse_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output pse_pkg::pse_entry_type pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pse_pkg::pse_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/pse_back.sv]
// Back end: unpacks queued entries into one result byte per transfer.
// Depends on pse_pkg and pse_rsp_if.
module pse_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  pse_pkg::pse_entry_type pop_entry,
   pse_rsp_if.source              rsp_if
);

   pse_pkg::pse_entry_type ent_ff, ent_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       eos_ff, eos_in;
   logic       ovf_ff, ovf_in;

   logic       out_free, emitting, finishing;
   logic [1:0] last_idx;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_if.ready;
      emitting  = busy_ff && out_free;
      last_idx  = (ent_ff.count == '0) ? 2'd0 : 2'(ent_ff.count - 3'd1);
      finishing = emitting && (idx_ff == last_idx);
      pop_ready = !busy_ff || finishing;

      ent_in        = ent_ff;
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      eos_in        = eos_ff;
      ovf_in        = ovf_ff;

      if (emitting) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = ent_ff.bytes[idx_ff];
         byte_valid_in = (ent_ff.count != '0);
         eos_in        = ent_ff.last && (idx_ff == last_idx);
         ovf_in        = ent_ff.ovf;
         idx_in        = idx_ff + 2'd1;
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         ent_in  = pop_entry;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      eos_ff        <= eos_in;
      ovf_ff        <= ovf_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.out_byte      = out_byte_ff;
   assign rsp_if.byte_valid    = byte_valid_ff;
   assign rsp_if.end_of_string = eos_ff;
   assign rsp_if.overflow      = ovf_ff;

endmodule

[hdl/pdf_string_escape_codec.sv]
// PDF string escape codec: literal string escape, name escape, hex encode and
// hex decode of a byte stream, with an output capacity limit and sticky overflow.
// Channels: req_if takes one source byte and its last_byte mark per transfer;
// rsp_if gives one result byte per transfer with byte_valid, end_of_string and
// overflow; csr_if writes mode (index 0) and out_capacity (index 1), always ready.
// A source byte expands into zero to four result bytes; a final byte that yields
// none gives one bare end marker with byte_valid low.
// A byte's first result passes the entry queue, the back end's entry register
// and the result register. Throughput: one source byte per cycle while the
// queue has room, one result byte per cycle while the receiver is ready, up to
// four per byte (for an octal escape), through the single-byte result register.
// The front end and the back end meet at a QUEUE_DEPTH entry queue; when the
// receiver stalls, the result register holds, the queue fills, and req_if.ready
// drops once the queue is full.
// Reset clears the queue, the result register, the string state, mode to
// literal escape and out_capacity to all ones.
// Depends on pse_pkg, the three channel interfaces, pse_front, pse_queue, pse_back.
module pdf_string_escape_codec #(
   parameter int COUNT_WIDTH = 24,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   pse_req_if.sink    req_if,
   pse_rsp_if.source  rsp_if,
   pse_csr_if.sink    csr_if
);

   logic                   push_valid, push_ready;
   pse_pkg::pse_entry_type push_entry;
   logic                   pop_valid, pop_ready;
   pse_pkg::pse_entry_type pop_entry;

   pse_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   pse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   pse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule
